// File: rtl/dcf77_pkg.sv
// Shared types and constants for the DCF77 binary telegram decoder.
package dcf77_pkg;

   localparam int unsigned CNT_W = 4;

   localparam logic [7:0] TERMINATOR = 8'hFD;
   localparam logic [CNT_W-1:0] FRAME_LEN = 4'd11;
   localparam logic [CNT_W-1:0] COUNT_MAX = 4'd15;
   localparam logic [7:0] TZ_MASK = 8'h0C;
   localparam logic [7:0] TZ_MET = 8'h08;
   localparam logic [7:0] TZ_MEST = 8'h04;
   localparam logic [7:0] TX_LEAP = 8'h10;
   localparam logic [7:0] TX_CALL = 8'h01;
   localparam logic [7:0] TX_ANNOUNCE = 8'h02;
   localparam logic [7:0] CS_TIME = 8'h01;
   localparam logic [7:0] CS_SIGNAL = 8'h02;
   localparam logic [19:0] TENTH_US = 20'd100000;
   localparam logic signed [13:0] OFFS_MET = -14'sd3600;
   localparam logic signed [13:0] OFFS_MEST = -14'sd7200;

   // result status codes
   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_FORMAT = 3'd1;
   localparam logic [2:0] ST_TIME = 3'd2;
   localparam logic [2:0] ST_DATE = 3'd3;
   localparam logic [2:0] ST_ZONE = 3'd4;

   // Buffered frame as seen by the decoder; byte 9 is never used.
   typedef struct packed {
      logic            len_ok;
      logic [8:0][7:0] bytes;
   } frame_type;

   typedef struct packed {
      logic [7:0]         flags;
      logic signed [13:0] utc_offset_seconds;
      logic [6:0]         year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic [19:0]        microsecond;
      logic [5:0]         second;
      logic [5:0]         minute;
      logic [4:0]         hour;
      logic [2:0]         status;
   } result_type;

endpackage

// File: rtl/dcf77_frame_buf.sv
// Frame byte store and saturating byte counter.
module dcf77_frame_buf #(
   parameter int unsigned BUFFER_DEPTH = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [7:0]          wr_byte,
   output dcf77_pkg::frame_type frame
);
   import dcf77_pkg::*;

   localparam int unsigned IDX_W = $clog2(BUFFER_DEPTH);
   localparam logic [CNT_W-1:0] CNT_LIM =
      (BUFFER_DEPTH < 15) ? CNT_W'(BUFFER_DEPTH) : COUNT_MAX;

   logic [7:0]       buf_ff [BUFFER_DEPTH];
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             has_room;
   logic             is_term;

   assign has_room = (cnt_ff < CNT_LIM);
   assign is_term  = (wr_byte == TERMINATOR);

   always_comb begin
      cnt_in = cnt_ff;
      if (wr_en) begin
         if (is_term) begin
            cnt_in = '0;
         end else if (has_room) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && has_room) begin
         buf_ff[cnt_ff[IDX_W-1:0]] <= wr_byte;
      end
   end

   // Right length only if the terminator lands in the eleventh slot.
   always_comb begin
      frame.len_ok = (cnt_ff == FRAME_LEN - 1'b1);
      for (int i = 0; i < 9; i++) begin
         frame.bytes[i] = buf_ff[i];
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_LIM)
      else $error("byte count above limit");

   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      wr_en && is_term |=> cnt_ff == '0)
      else $error("count not cleared after terminator");

endmodule

// File: rtl/dcf77_decode.sv
// Field range checks and result formatting for one closed frame.
module dcf77_decode (
   input  dcf77_pkg::frame_type  frame,
   output dcf77_pkg::result_type result
);
   import dcf77_pkg::*;

   logic [7:0] b0, b1, b2, b3, b4, b5, b6, cs, tx, tz;
   logic       time_bad, date_bad, is_met, is_mest;
   logic [2:0] status;
   logic [7:0] fl;

   assign b0 = frame.bytes[0];
   assign b1 = frame.bytes[1];
   assign b2 = frame.bytes[2];
   assign b3 = frame.bytes[3];
   assign b4 = frame.bytes[4];
   assign b5 = frame.bytes[5];
   assign b6 = frame.bytes[6];
   assign cs = frame.bytes[7];
   assign tx = frame.bytes[8];
   assign tz = tx & TZ_MASK;

   assign time_bad = (b0 > 8'd23) || (b1 > 8'd59) || (b2 > 8'd59) || (b3 > 8'd9);
   assign date_bad = (b4 < 8'd1) || (b4 > 8'd31) || (b5 < 8'd1) || (b5 > 8'd12)
                     || (b6 > 8'd99);
   assign is_met  = (tz == TZ_MET);
   assign is_mest = (tz == TZ_MEST);

   always_comb begin
      if (!frame.len_ok) begin
         status = ST_FORMAT;
      end else if (time_bad) begin
         status = ST_TIME;
      end else if (date_bad) begin
         status = ST_DATE;
      end else if (!is_met && !is_mest) begin
         status = ST_ZONE;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      fl    = 8'hC0;
      fl[0] = is_mest;
      fl[1] = ((cs & CS_TIME) == 8'h00);
      if ((cs & CS_SIGNAL) == 8'h00) begin
         fl[2] = 1'b1;
      end else begin
         fl[3] = ((tx & TX_CALL) != 8'h00);
         fl[4] = ((tx & TX_ANNOUNCE) != 8'h00);
         fl[5] = ((tx & TX_LEAP) != 8'h00);
      end
   end

   // All fields but status read zero unless the frame decodes cleanly.
   always_comb begin
      result        = '0;
      result.status = status;
      if (status == ST_OK) begin
         result.hour        = b0[4:0];
         result.minute      = b1[5:0];
         result.second      = b2[5:0];
         result.microsecond = 20'(b3[3:0]) * TENTH_US;
         result.day         = b4[4:0];
         result.month       = b5[3:0];
         result.year        = b6[6:0];
         result.utc_offset_seconds = is_mest ? OFFS_MEST : OFFS_MET;
         result.flags       = fl;
      end
   end

endmodule

// File: rtl/dcf77_binary_telegram_decoder_core.sv
// Top level of the DCF77 binary telegram decoder.
//
//  channel | dir | tdata fields (lsb first)                      | tlast/tuser
//  --------+-----+-----------------------------------------------+------------
//  req_    | in  | rx_byte[7:0]                                  | none
//  rsp_    | out | status, hour, minute, second, microsecond,    | none
//          |     | day, month, year, utc_offset_seconds, flags   |
//
//  One item per cycle sustained while no terminator waits on the output register:
//  an input register feeds the byte store and the decode logic, whose result is registered in the output register.
//  rsp_tvalid rises once the terminator has left the input register and its result is registered.
//  Synchronous active-high reset clears the byte count and both valid flags;
//  buffer contents are left undefined.
//  Only a terminator waits on a full output register; other bytes keep flowing
//  while a result sits unclaimed.
module dcf77_binary_telegram_decoder_core #(
   parameter int unsigned BUFFER_DEPTH = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] status, [7:3] hour, [13:8] minute, [19:14] second,
   // [39:20] microsecond, [44:40] day, [48:45] month, [55:49] year,
   // [69:56] utc_offset_seconds, [77:70] flags, [79:78] zero
   output logic [79:0] rsp_tdata
);
   import dcf77_pkg::*;

   // input stage
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff, in_byte_in;
   // output stage
   logic       rsp_vld_ff, rsp_vld_in;
   result_type rsp_data_ff, rsp_data_in;

   logic       req_acc;
   logic       is_term;
   logic       proc_go;   // input stage item moves on this cycle
   frame_type  frame;
   result_type result;

   assign is_term = (in_byte_ff == TERMINATOR);
   // a terminator needs room in the output register, other bytes never wait
   assign proc_go = in_vld_ff && (!is_term || !rsp_vld_ff || rsp_tready);

   assign req_tready = !in_vld_ff || proc_go;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      if (req_acc) begin
         in_vld_in  = 1'b1;
         in_byte_in = req_tdata;
      end else if (proc_go) begin
         in_vld_in = 1'b0;
      end
   end

   dcf77_frame_buf #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_frame_buf (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (proc_go),
      .wr_byte (in_byte_ff),
      .frame   (frame)
   );

   dcf77_decode u_decode (
      .frame  (frame),
      .result (result)
   );

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (proc_go && is_term) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = result;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

   a_ok_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_data_ff.status == ST_OK |->
         rsp_data_ff.hour <= 5'd23 && rsp_data_ff.minute <= 6'd59 &&
         rsp_data_ff.second <= 6'd59 && rsp_data_ff.month <= 4'd12)
      else $error("ok result with field out of range");

   a_ok_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_data_ff.status == ST_OK |->
         rsp_data_ff.utc_offset_seconds == OFFS_MET ||
         rsp_data_ff.utc_offset_seconds == OFFS_MEST)
      else $error("ok result with bad utc offset");

   a_bad_zeroed: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_data_ff.status != ST_OK |->
         rsp_data_ff.flags == 8'h00 && rsp_data_ff.microsecond == 20'd0)
      else $error("failed result carries nonzero fields");

   a_term_result: assert property (@(posedge clock) disable iff (reset)
      proc_go && is_term |=> rsp_vld_ff)
      else $error("terminator did not produce a result");

endmodule
